// ----- rtl/rsk_pkg.sv -----
// Shared types, codes and key functions of the record sorter.
package rsk_pkg;

    localparam int TIME_W     = 40;
    localparam int TEXT_W     = 152;
    localparam int TIME_BYTES = TIME_W / 8;
    localparam int TEXT_BYTES = TEXT_W / 8;
    localparam int KEY_W      = TEXT_W;

    // One record, every text with its first character in the top byte.
    typedef struct packed {
        logic [TIME_W-1:0] time_text;
        logic [TEXT_W-1:0] origin;
        logic [TEXT_W-1:0] dest;
    } record_t;

    // A record together with its comparison key.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        record_t          rec;
    } entry_t;

    typedef enum logic [1:0] {
        KEY_TIME   = 2'd0,
        KEY_ORIGIN = 2'd1,
        KEY_DEST   = 2'd2,
        KEY_NONE   = 2'd3
    } sort_key_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    // Chain control broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctl_t;

    // Clears every byte after the first zero byte, so a plain unsigned compare of
    // two keys gives the same order as a C string compare.
    function automatic logic [TEXT_W-1:0] text_key(input logic [TEXT_W-1:0] t);
        logic [TEXT_W-1:0] k;
        logic              seen_zero;
        k         = '0;
        seen_zero = 1'b0;
        for (int i = 0; i < TEXT_BYTES; i++) begin
            if (!seen_zero) begin
                k[TEXT_W-1-8*i -: 8] = t[TEXT_W-1-8*i -: 8];
            end
            if (t[TEXT_W-1-8*i -: 8] == 8'd0) begin
                seen_zero = 1'b1;
            end
        end
        return k;
    endfunction

    function automatic logic [TIME_W-1:0] time_key(input logic [TIME_W-1:0] t);
        logic [TIME_W-1:0] k;
        logic              seen_zero;
        k         = '0;
        seen_zero = 1'b0;
        for (int i = 0; i < TIME_BYTES; i++) begin
            if (!seen_zero) begin
                k[TIME_W-1-8*i -: 8] = t[TIME_W-1-8*i -: 8];
            end
            if (t[TIME_W-1-8*i -: 8] == 8'd0) begin
                seen_zero = 1'b1;
            end
        end
        return k;
    endfunction

    // Key of a record under the selected ordering; the unused code makes all keys equal.
    function automatic logic [KEY_W-1:0] key_of(input sort_key_t sel, input record_t r);
        logic [KEY_W-1:0] k;
        case (sel)
            KEY_TIME:   k = {{(KEY_W-TIME_W){1'b0}}, time_key(r.time_text)};
            KEY_ORIGIN: k = text_key(r.origin);
            KEY_DEST:   k = text_key(r.dest);
            default:    k = '0;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/rsk_cell.sv -----
// One cell of the sorting chain: holds one record and its key.
module rsk_cell
    import rsk_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  chain_ctl_t ctl,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  logic       left_vld,
    input  logic       left_gt,
    input  entry_t     right_entry,
    input  logic       right_vld,
    output entry_t     entry,
    output logic       vld,
    output logic       gt
);

    entry_t entry_reg, entry_next;
    logic   vld_reg, vld_next;

    // An empty cell counts as larger than anything; ties do not count, which keeps
    // the sort stable.
    assign gt = !vld_reg || (entry_reg.key > new_entry.key);

    always_comb begin
        entry_next = entry_reg;
        vld_next   = vld_reg;
        if (ctl.insert && gt) begin
            if (left_gt) begin
                entry_next = left_entry;
                vld_next   = left_vld;
            end else begin
                entry_next = new_entry;
                vld_next   = 1'b1;
            end
        end else if (ctl.shift) begin
            entry_next = right_entry;
            vld_next   = right_vld;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign entry = entry_reg;
    assign vld   = vld_reg;

endmodule

// ----- rtl/record_sorter_by_selected_key_top.sv -----
// Top level of the record sorter: a systolic insertion chain with load and drain control.
//
//   Channel | Direction | Handshake          | Content
//   s_*     | in        | s_valid / s_ready  | one record, s_last_record ends the set
//   m_*     | out       | m_valid / m_ready  | one record in sorted order, flags
//   cfg_*   | in        | cfg_wr_en          | sort_key, two bits
//
// Flow: during loading one record transfer is taken in every cycle; each record
// drops into its sorted place in the chain of MAX_RECORDS cells in that same cycle.
// After the transfer marked last, the chain drains one sorted record per cycle while
// m_ready is high, through cell 0, which serves as the output register; no input is
// taken while draining. Reset clears the state machine, the record count, the
// overflow flag, the key selection and the cell valid bits. A stall on m_ready simply
// holds the chain.
module record_sorter_by_selected_key_top
    import rsk_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [39:0] s_time_text,
    input  logic [63:0] s_origin_hi,
    input  logic [63:0] s_origin_mid,
    input  logic [23:0] s_origin_lo,
    input  logic [63:0] s_dest_hi,
    input  logic [63:0] s_dest_mid,
    input  logic [23:0] s_dest_lo,
    input  logic        s_last_record,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [39:0] m_out_time,
    output logic [63:0] m_out_origin_hi,
    output logic [63:0] m_out_origin_mid,
    output logic [23:0] m_out_origin_lo,
    output logic [63:0] m_out_dest_hi,
    output logic [63:0] m_out_dest_mid,
    output logic [23:0] m_out_dest_lo,
    output logic        m_last_out,
    output logic        m_overflowed
);

    // The count must be able to hold MAX_RECORDS itself.
    localparam int CW = $clog2(MAX_RECORDS + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            ovf_reg, ovf_next;
    sort_key_t       sort_key_reg;

    chain_ctl_t      ctl;
    record_t         in_rec;
    entry_t          in_entry;
    logic            s_xfer, m_xfer, full;

    entry_t          cell_entry [MAX_RECORDS];
    logic            cell_vld   [MAX_RECORDS];
    logic            cell_gt    [MAX_RECORDS];

    // The selected key is computed once on the incoming record and travels with it.
    assign in_rec.time_text = s_time_text;
    assign in_rec.origin    = {s_origin_hi, s_origin_mid, s_origin_lo};
    assign in_rec.dest      = {s_dest_hi, s_dest_mid, s_dest_lo};
    assign in_entry.rec     = in_rec;
    assign in_entry.key     = key_of(sort_key_reg, in_rec);

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_DRAIN);
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;
    assign full    = (count_reg == CW'(MAX_RECORDS));

    // A record that finds the chain full is dropped and only raises the overflow flag.
    assign ctl.insert = s_xfer && !full;
    assign ctl.shift  = m_xfer;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sort_key_reg <= KEY_TIME;
        end else if (cfg_wr_en) begin
            sort_key_reg <= sort_key_t'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // While loading the count grows; while draining it counts the records still to go.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_xfer) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_last_record) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (m_xfer) begin
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1)) begin
                        state_next = ST_LOAD;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // The chain is kept sorted from cell 0 upward, with empty cells at the far end.
    // On an insert the cells holding larger keys move one place up and the new record
    // lands in the first of them. On a drain every cell takes its upper neighbor.
    for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
        entry_t left_entry, right_entry;
        logic   left_vld, left_gt, right_vld;

        if (i == 0) begin : g_first
            assign left_entry = cell_entry[i];
            assign left_vld   = 1'b0;
            assign left_gt    = 1'b0;
        end else begin : g_inner_left
            assign left_entry = cell_entry[i-1];
            assign left_vld   = cell_vld[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == MAX_RECORDS - 1) begin : g_last
            assign right_entry = cell_entry[i];
            assign right_vld   = 1'b0;
        end else begin : g_inner_right
            assign right_entry = cell_entry[i+1];
            assign right_vld   = cell_vld[i+1];
        end

        rsk_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .new_entry   (in_entry),
            .left_entry  (left_entry),
            .left_vld    (left_vld),
            .left_gt     (left_gt),
            .right_entry (right_entry),
            .right_vld   (right_vld),
            .entry       (cell_entry[i]),
            .vld         (cell_vld[i]),
            .gt          (cell_gt[i])
        );
    end

    // Cell 0 holds the smallest remaining record and drives the result channel.
    assign m_out_time       = cell_entry[0].rec.time_text;
    assign m_out_origin_hi  = cell_entry[0].rec.origin[151:88];
    assign m_out_origin_mid = cell_entry[0].rec.origin[87:24];
    assign m_out_origin_lo  = cell_entry[0].rec.origin[23:0];
    assign m_out_dest_hi    = cell_entry[0].rec.dest[151:88];
    assign m_out_dest_mid   = cell_entry[0].rec.dest[87:24];
    assign m_out_dest_lo    = cell_entry[0].rec.dest[23:0];
    assign m_last_out       = (count_reg == CW'(1));
    assign m_overflowed     = ovf_reg;

endmodule
